// ----- src/brcp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brcp_pkg: shared types and constants for the block-read command parser
// Character codes, value width, parser phase encoding and the result record.
// ----------------------------------------------------------------------------
package brcp_pkg;

  localparam int VALUE_WIDTH = 16;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [3:0] {
    PH_SKIP0  = 4'd0,
    PH_SKIP1  = 4'd1,
    PH_PRE_CH = 4'd2,
    PH_CH     = 4'd3,
    PH_PRE_DR = 4'd4,
    PH_DR     = 4'd5,
    PH_PRE_TR = 4'd6,
    PH_TR     = 4'd7,
    PH_PRE_SE = 4'd8,
    PH_SE     = 4'd9,
    PH_DONE   = 4'd10,
    PH_ERR    = 4'd11
  } phase_t;

  typedef struct packed {
    logic                   status;
    logic [VALUE_WIDTH-1:0] channel;
    logic [VALUE_WIDTH-1:0] drive;
    logic [VALUE_WIDTH-1:0] track;
    logic [VALUE_WIDTH-1:0] sector;
  } res_t;

endpackage
`default_nettype wire

// ----- src/brcp_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brcp_parser: phase tracker and number accumulators
// Consumes one character per accepted request and emits the parsed command
// on the request flagged as last.
// ----------------------------------------------------------------------------
module brcp_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   cmd_byte,
  input  wire logic         last,
  output logic              res_valid,
  output brcp_pkg::res_t    res
);
  import brcp_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [VALUE_WIDTH-1:0] ch_r, dr_r, tr_r, se_r;
  logic [VALUE_WIDTH-1:0] ch_nxt, dr_nxt, tr_nxt, se_nxt;
  logic [VALUE_WIDTH-1:0] acc_cur, acc_upd;
  logic [VALUE_WIDTH+3:0] acc_ext;
  logic                   is_digit, is_space, is_colon, wr;
  logic [3:0]             digit;

  assign is_digit = (cmd_byte >= CHAR_ZERO) && (cmd_byte <= CHAR_NINE);
  assign is_space = (cmd_byte == CHAR_SPACE);
  assign is_colon = (cmd_byte == CHAR_COLON);
  assign digit    = 4'(cmd_byte - CHAR_ZERO);

  // pick the accumulator the current phase feeds
  always_comb begin
    case (phase_r)
      PH_PRE_CH, PH_CH: acc_cur = ch_r;
      PH_PRE_DR, PH_DR: acc_cur = dr_r;
      PH_PRE_TR, PH_TR: acc_cur = tr_r;
      default:          acc_cur = se_r;
    endcase
  end

  // acc * 10 + digit, saturating
  assign acc_ext = ({4'd0, acc_cur} << 3) + ({4'd0, acc_cur} << 1)
                 + {{VALUE_WIDTH{1'b0}}, digit};
  assign acc_upd = (acc_ext > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc_ext[VALUE_WIDTH-1:0];

  always_comb begin
    phase_nxt = phase_r;
    wr        = 1'b0;
    case (phase_r)
      PH_SKIP0: phase_nxt = PH_SKIP1;
      PH_SKIP1: phase_nxt = PH_PRE_CH;
      PH_PRE_CH, PH_PRE_DR, PH_PRE_TR, PH_PRE_SE: begin
        if (is_digit) begin
          phase_nxt = phase_t'(phase_r + 4'd1);
          wr        = 1'b1;
        end else if (is_space || (phase_r == PH_PRE_CH && is_colon)) begin
          phase_nxt = phase_r;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_CH, PH_DR, PH_TR, PH_SE: begin
        if (is_digit) begin
          wr = 1'b1;
        end else if (is_space) begin
          phase_nxt = phase_t'(phase_r + 4'd1);
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_comb begin
    ch_nxt = ch_r;
    dr_nxt = dr_r;
    tr_nxt = tr_r;
    se_nxt = se_r;
    if (wr) begin
      case (phase_r)
        PH_PRE_CH, PH_CH: ch_nxt = acc_upd;
        PH_PRE_DR, PH_DR: dr_nxt = acc_upd;
        PH_PRE_TR, PH_TR: tr_nxt = acc_upd;
        default:          se_nxt = acc_upd;
      endcase
    end
  end

  assign res_valid = accept && last;

  always_comb begin
    if (phase_nxt == PH_ERR) begin
      res = '{status: 1'b1, channel: '0, drive: '0, track: '0, sector: '0};
    end else begin
      res = '{status: 1'b0, channel: ch_nxt, drive: dr_nxt, track: tr_nxt, sector: se_nxt};
    end
  end

  // return to the reset state once the last request is consumed
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last)) begin
      phase_r <= PH_SKIP0;
      ch_r    <= '0;
      dr_r    <= '0;
      tr_r    <= '0;
      se_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      ch_r    <= ch_nxt;
      dr_r    <= dr_nxt;
      tr_r    <= tr_nxt;
      se_r    <= se_nxt;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (phase_r == PH_SKIP0 && ch_r == '0 && se_r == '0))
    else $error("parser did not restart after last request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status) |-> (res.channel == '0 && res.sector == '0))
    else $error("error result carries nonzero fields");

endmodule
`default_nettype wire

// ----- src/brcp_out_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// brcp_out_buf: two-entry result buffer
// Decouples the result channel stall from the parser so a request can be
// taken while a finished result still waits.
// ----------------------------------------------------------------------------
module brcp_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire brcp_pkg::res_t push_res,
  input  wire logic           out_stall,
  output logic                out_valid,
  output logic                full,
  output brcp_pkg::res_t      head
);
  import brcp_pkg::*;

  logic [1:0] count_r, count_nxt;
  res_t       slot0_r, slot1_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid && !out_stall;
  assign head      = slot0_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // payload: head refills from the second slot or straight from the parser
  always_ff @(posedge clk) begin
    if (count_r == 2'd2 && pop) begin
      slot0_r <= slot1_r;
    end else if (push && (count_r == 2'd0 || (count_r == 2'd1 && pop))) begin
      slot0_r <= push_res;
    end
    if (push && count_r == 2'd1 && !pop) begin
      slot1_r <= push_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("result pushed into full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("result buffer count out of range");

endmodule
`default_nettype wire

// ----- src/block_read_command_parser_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// block_read_command_parser_core: block-read command text parser
// Parses channel, drive, track and sector numbers from a command byte stream.
// ----------------------------------------------------------------------------
// One command character is taken per cycle, back to back, while in_stall
// is low; the phase and accumulator update for a character settles within
// that cycle, and the result of the last-flagged character is registered
// into a two-entry result buffer whose head drives the result channel, so
// input continues while a result stalls, and stalls only when both are held.
// The first two characters are skipped, colons may precede the channel,
// spaces separate numbers, any other character before the space ending the
// sector gives status 1 with zero fields; numbers saturate at the all-ones value.
module block_read_command_parser_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_command_byte,
  input  wire logic                             in_last_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_status,
  output logic [brcp_pkg::VALUE_WIDTH-1:0]      out_channel,
  output logic [brcp_pkg::VALUE_WIDTH-1:0]      out_drive,
  output logic [brcp_pkg::VALUE_WIDTH-1:0]      out_track,
  output logic [brcp_pkg::VALUE_WIDTH-1:0]      out_sector
);
  import brcp_pkg::*;

  logic accept, res_valid, full;
  res_t res, head;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  brcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cmd_byte  (in_command_byte),
    .last      (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  brcp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .full      (full),
    .head      (head)
  );

  assign out_status  = head.status;
  assign out_channel = head.channel;
  assign out_drive   = head.drive;
  assign out_track   = head.track;
  assign out_sector  = head.sector;

endmodule
`default_nettype wire
